[src/fsh_pkg.sv]
package fsh_pkg;

    localparam int CH_W      = 8;
    localparam int OUT_W     = 3 * CH_W;
    localparam int NRM_W     = 15;
    localparam int N_W       = 16;
    localparam int SQ_W      = 2 * NRM_W;
    localparam int Q2_W      = 32;
    localparam int X_W       = 60;
    localparam int RT_W      = 30;
    localparam int SQ_N      = 30;
    localparam int SQ_REM_W  = 32;
    localparam int D_W       = 33;
    localparam int DM_W      = 32;
    localparam int DOT_FRAC  = 14;
    localparam int NUM_W     = DM_W + DOT_FRAC;
    localparam int QT_W      = 18;
    localparam int DIV_N     = QT_W;
    localparam int DOT_W     = QT_W + 1;
    localparam int IK_W      = 24;
    localparam int PROD_W    = IK_W + 1 + DOT_W;
    localparam int ACC_W     = 47;
    localparam int FRAC_SH   = 29;
    localparam int CFG_W     = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int LIGHT_STRIDE = 2;

    localparam logic [CH_W-1:0] CH_MAX  = 8'hFF;
    localparam logic [QT_W-1:0] QUO_MAX = 18'd196608;

    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_COUNT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFFUSE_COEFFS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_L0_INTENSITY   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_L0_DIRECTION   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_L1_INTENSITY   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_L1_DIRECTION   = 3'd5;

    typedef logic [CH_W-1:0] chan_t;

endpackage

[src/flat_directional_shading.sv]
// Flat Lambert shading of one polygon per beat, up to MAX_LIGHTS directional lights.
// Throughput: one beat per cycle; the whole pipeline advances together and halts
// only while the output register holds a beat the sink has not taken.
// The pipeline holds the 30-stage square root and the 18-stage divider. Reset
// clears all valid bits and the configuration registers; result data registers
// are not reset.
module flat_directional_shading
    import fsh_pkg::*;
#(
    parameter int MAX_LIGHTS  = 2,
    parameter int NORMAL_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // normal_x, normal_y, normal_z, base_red, base_green, base_blue (low bit up)
    input  logic [((3*NORMAL_BITS+3*CH_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red, green, blue (low bit up)
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int P_W     = $clog2(NORMAL_BITS);
    localparam int S_SUM   = 4;
    localparam int S_ROOT  = S_SUM + SQ_N;
    localparam int S_QUO   = S_ROOT + DIV_N;
    localparam int S_PROD  = S_QUO + 1;
    localparam int S_ACC   = S_PROD + 1;

    // beat side-band: travels with every stage
    typedef struct packed {
        logic                             vld;
        logic [MAX_LIGHTS-1:0]            live;
        logic [MAX_LIGHTS-1:0]            neg;
        logic [MAX_LIGHTS-1:0][DM_W-1:0]  dm;
        logic [2:0][CH_W-1:0]             base;
    } side_t;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [1:0]        light_count_reg;
    logic [CFG_W-1:0]  kd_reg;
    logic [OUT_W-1:0]  inten_reg [MAX_LIGHTS];
    logic [CFG_W-1:0]  dir_reg   [MAX_LIGHTS];
    logic [IK_W-1:0]   ik_reg    [MAX_LIGHTS][3];
    logic [1:0]        lights_eff;
    logic [MAX_LIGHTS-1:0] light_on;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_count_reg <= '0;
            kd_reg          <= '0;
            for (int l = 0; l < MAX_LIGHTS; l++)
            begin
                inten_reg[l] <= '0;
                dir_reg[l]   <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LIGHT_COUNT:    light_count_reg <= cfg_wdata[1:0];
                REG_DIFFUSE_COEFFS: kd_reg          <= cfg_wdata;
                default:            ;
            endcase
            for (int l = 0; l < MAX_LIGHTS; l++)
            begin
                if (cfg_addr == CFG_ADDR_W'(int'(REG_L0_INTENSITY) + LIGHT_STRIDE*l))
                    inten_reg[l] <= cfg_wdata[OUT_W-1:0];
                if (cfg_addr == CFG_ADDR_W'(int'(REG_L0_DIRECTION) + LIGHT_STRIDE*l))
                    dir_reg[l] <= cfg_wdata;
            end
        end
    end

    // intensity times coefficient per light and channel, registered from the configuration registers
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MAX_LIGHTS; l++)
            for (int c = 0; c < 3; c++)
                ik_reg[l][c] <= IK_W'(inten_reg[l][CH_W*c +: CH_W] * kd_reg[16*c +: 16]);
    end

    // saturate the light count to what the block carries
    assign lights_eff = (light_count_reg > 2'(MAX_LIGHTS)) ? 2'(MAX_LIGHTS) : light_count_reg;

    always_comb
    begin
        for (int l = 0; l < MAX_LIGHTS; l++)
            light_on[l] = (2'(l) < lights_eff);
    end

    // ---------------------------------------------------------------------
    // Flow control: everything advances together behind the output register
    // ---------------------------------------------------------------------
    logic             adv;
    logic             m_vld_reg;
    logic [OUT_W-1:0] m_data_reg;

    assign adv           = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

    side_t side_reg  [S_ACC+1];
    side_t side_next [S_ACC+1];

    // ---------------------------------------------------------------------
    // Front end: magnitudes, leading one, normalise, squares and dots
    // ---------------------------------------------------------------------
    logic [NORMAL_BITS-1:0] mag0_reg [3];
    logic [2:0]             sgn0_reg;
    logic [NORMAL_BITS-1:0] mag1_reg [3];
    logic [2:0]             sgn1_reg;
    logic [P_W-1:0]         p1_reg;
    logic [NRM_W-1:0]       mag2_reg [3];
    logic [2:0]             sgn2_reg;
    logic [SQ_W-1:0]        sq3_reg  [3];
    logic signed [D_W-1:0]  d3_reg   [MAX_LIGHTS];
    logic [Q2_W-1:0]        q2_reg;

    logic [NORMAL_BITS-1:0] mag0_next [3];
    logic [NORMAL_BITS-1:0] ormag;
    logic [P_W-1:0]         p_next;
    logic [NRM_W-1:0]       mag2_next [3];
    logic signed [D_W-1:0]  d_next    [MAX_LIGHTS];
    logic [Q2_W-1:0]        q2_next;

    always_comb
    begin
        logic [NORMAL_BITS-1:0]       raw;
        logic [NORMAL_BITS+NRM_W-1:0] ext;
        logic signed [N_W-1:0]        nv;
        logic signed [D_W-1:0]        dsum;

        // take magnitudes, sign kept apart
        for (int c = 0; c < 3; c++)
        begin
            raw          = s_axis_tdata[c*NORMAL_BITS +: NORMAL_BITS];
            mag0_next[c] = raw[NORMAL_BITS-1] ? NORMAL_BITS'(-raw) : raw;
        end

        // leading one of the largest magnitude equals that of the OR of all three
        ormag  = mag0_reg[0] | mag0_reg[1] | mag0_reg[2];
        p_next = '0;
        for (int b = 0; b < NORMAL_BITS; b++)
            if (ormag[b])
                p_next = P_W'(b);

        // bring the largest magnitude into [2^14, 2^15)
        for (int c = 0; c < 3; c++)
        begin
            ext = {{NRM_W{1'b0}}, mag1_reg[c]};
            if (int'(p1_reg) >= NRM_W - 1)
                ext = ext >> (int'(p1_reg) - (NRM_W - 1));
            else
                ext = ext << ((NRM_W - 1) - int'(p1_reg));
            mag2_next[c] = ext[NRM_W-1:0];
        end

        // dot of each light direction with the scaled normal
        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            dsum = '0;
            for (int c = 0; c < 3; c++)
            begin
                nv = $signed({1'b0, mag2_reg[c]});
                if (sgn2_reg[c])
                    nv = -nv;
                dsum = dsum + D_W'($signed(dir_reg[l][16*c +: 16]) * nv);
            end
            d_next[l] = dsum;
        end

        q2_next = Q2_W'(sq3_reg[0]) + Q2_W'(sq3_reg[1]) + Q2_W'(sq3_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag0_reg[c] <= mag0_next[c];
                sgn0_reg[c] <= s_axis_tdata[c*NORMAL_BITS + NORMAL_BITS - 1];
                mag1_reg[c] <= mag0_reg[c];
                mag2_reg[c] <= mag2_next[c];
                sq3_reg[c]  <= SQ_W'(mag2_reg[c] * mag2_reg[c]);
            end
            sgn1_reg <= sgn0_reg;
            sgn2_reg <= sgn1_reg;
            p1_reg   <= p_next;
            for (int l = 0; l < MAX_LIGHTS; l++)
                d3_reg[l] <= d_next[l];
            q2_reg <= q2_next;
        end
    end

    // ---------------------------------------------------------------------
    // Side-band line
    // ---------------------------------------------------------------------
    always_comb
    begin
        side_next[0]      = '0;
        side_next[0].vld  = s_axis_tvalid;
        for (int c = 0; c < 3; c++)
            side_next[0].base[c] = s_axis_tdata[3*NORMAL_BITS + CH_W*c +: CH_W];
        for (int k = 1; k <= S_ACC; k++)
            side_next[k] = side_reg[k-1];
        // a zero normal or a disabled light adds nothing
        side_next[1].live = (ormag != '0) ? light_on : '0;
        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            side_next[S_SUM].neg[l] = d3_reg[l][D_W-1];
            side_next[S_SUM].dm[l]  = d3_reg[l][D_W-1] ? DM_W'(-d3_reg[l]) : DM_W'(d3_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S_ACC; k++)
                side_reg[k].vld <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k <= S_ACC; k++)
                side_reg[k] <= side_next[k];
        end
    end

    // ---------------------------------------------------------------------
    // Length of the scaled normal, then |D| * 2^14 / length per light
    // ---------------------------------------------------------------------
    logic [RT_W-1:0] root;
    logic [QT_W-1:0] quo [MAX_LIGHTS];

    fsh_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (adv),
        .x    ({q2_reg, {(X_W-Q2_W){1'b0}}}),
        .root (root)
    );

    for (genvar l = 0; l < MAX_LIGHTS; l++)
    begin : g_light
        fsh_div u_div
        (
            .clk (clk),
            .en  (adv),
            .num ({side_reg[S_ROOT].dm[l], {DOT_FRAC{1'b0}}}),
            .den (root),
            .quo (quo[l])
        );
    end

    // ---------------------------------------------------------------------
    // Back end: weight, accumulate, floor and clamp
    // ---------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg [MAX_LIGHTS][3];
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic signed [PROD_W-1:0] prod_next [MAX_LIGHTS][3];
    logic signed [ACC_W-1:0]  acc_next  [3];
    logic [OUT_W-1:0]         out_next;

    always_comb
    begin
        logic signed [DOT_W-1:0] dot;

        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            dot = $signed({1'b0, quo[l]});
            if (side_reg[S_QUO].neg[l])
                dot = -dot;
            for (int c = 0; c < 3; c++)
                prod_next[l][c] = side_reg[S_QUO].live[l] ?
                                  PROD_W'($signed({1'b0, ik_reg[l][c]}) * dot) : '0;
        end

        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = $signed({{(ACC_W-CH_W-FRAC_SH){1'b0}}, side_reg[S_PROD].base[c],
                                   {FRAC_SH{1'b0}}});
            for (int l = 0; l < MAX_LIGHTS; l++)
                acc_next[c] = acc_next[c] + ACC_W'(prod_reg[l][c]);
        end

        for (int c = 0; c < 3; c++)
        begin
            if (acc_reg[c][ACC_W-1])
                out_next[CH_W*c +: CH_W] = '0;
            else if (acc_reg[c][ACC_W-2:FRAC_SH+CH_W] != '0)
                out_next[CH_W*c +: CH_W] = CH_MAX;
            else
                out_next[CH_W*c +: CH_W] = acc_reg[c][FRAC_SH +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= prod_next;
            acc_reg    <= acc_next;
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (adv)
            m_vld_reg <= side_reg[S_ACC].vld;
    end

`ifndef SYNTHESIS
    // a live normal always has its largest component in [2^14, 2^15) after scaling
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (side_reg[2].vld && (side_reg[2].live != '0)) |->
        (mag2_reg[0][NRM_W-1] || mag2_reg[1][NRM_W-1] || mag2_reg[2][NRM_W-1]))
        else $error("scaled normal out of range");

    // the divider never sees a length below 2^28 for a live beat
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (side_reg[S_ROOT].vld && (side_reg[S_ROOT].live != '0)) |->
        (root[RT_W-1:RT_W-2] != 2'b00))
        else $error("normal length too small");

    // quotient bound that the divider's width relies on
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (side_reg[S_QUO].vld && side_reg[S_QUO].live[0]) |-> (quo[0] <= QUO_MAX))
        else $error("dot quotient overflow");

    // with no live light the base colour comes through unchanged
    a_pass_base: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && side_reg[S_ACC].vld && (side_reg[S_ACC].live == '0)) |=>
        (m_axis_tdata == $past(side_reg[S_ACC].base)))
        else $error("unlit beat altered");
`endif

endmodule

[src/fsh_sqrt.sv]
module fsh_sqrt
    import fsh_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [X_W-1:0]  x,
    output logic [RT_W-1:0] root
);

    logic [X_W-1:0]      x_reg   [SQ_N];
    logic [SQ_REM_W-1:0] rem_reg [SQ_N];
    logic [RT_W-1:0]     rt_reg  [SQ_N];

    // one root bit per stage, two radicand bits taken in each time
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_stage
        logic [X_W-1:0]      x_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [RT_W-1:0]     rt_in;
        logic [SQ_REM_W+1:0] rem_sh;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [RT_W-1:0]     rt_next;

        if (i == 0)
        begin : g_first
            assign x_in   = x;
            assign rem_in = '0;
            assign rt_in  = '0;
        end
        else
        begin : g_rest
            assign x_in   = x_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign rt_in  = rt_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {rem_in, x_in[2*(SQ_N-1-i)+1 -: 2]};
            trial  = {{(SQ_REM_W-RT_W){1'b0}}, rt_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next = SQ_REM_W'(rem_sh - trial);
                rt_next  = {rt_in[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = SQ_REM_W'(rem_sh);
                rt_next  = {rt_in[RT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= x_in;
                rem_reg[i] <= rem_next;
                rt_reg[i]  <= rt_next;
            end
        end
    end

    assign root = rt_reg[SQ_N-1];

endmodule

[src/fsh_div.sv]
module fsh_div
    import fsh_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [RT_W-1:0]  den,
    output logic [QT_W-1:0]  quo
);

    logic [NUM_W-1:0] num_reg [DIV_N];
    logic [RT_W-1:0]  den_reg [DIV_N];
    logic [RT_W-1:0]  rem_reg [DIV_N];
    logic [QT_W-1:0]  q_reg   [DIV_N];

    // quotient is known to fit QT_W bits, so the top of the numerator starts as remainder
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [RT_W-1:0]  den_in;
        logic [RT_W-1:0]  rem_in;
        logic [QT_W-1:0]  q_in;
        logic [RT_W:0]    rs;
        logic [RT_W-1:0]  rem_next;
        logic [QT_W-1:0]  q_next;

        if (j == 0)
        begin : g_first
            assign num_in = num;
            assign den_in = den;
            assign rem_in = {{(RT_W-(NUM_W-QT_W)){1'b0}}, num[NUM_W-1:QT_W]};
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        always_comb
        begin
            rs     = {rem_in, num_in[DIV_N-1-j]};
            q_next = q_in;
            if (rs >= {1'b0, den_in})
            begin
                rem_next            = RT_W'(rs - {1'b0, den_in});
                q_next[DIV_N-1-j]   = 1'b1;
            end
            else
            begin
                rem_next = RT_W'(rs);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[j] <= num_in;
                den_reg[j] <= den_in;
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign quo = q_reg[DIV_N-1];

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import fsh_pkg::*;

    localparam int NB     = 24;
    localparam int IN_W   = ((3*NB+3*CH_W+7)/8)*8;
    localparam int LIMIT  = 400000;
    localparam int SETTLE = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // normal_x, normal_y, normal_z, base_red, base_green, base_blue (low bit up)
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // red, green, blue (low bit up)
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    flat_directional_shading #(.MAX_LIGHTS(2), .NORMAL_BITS(NB)) u_dut (.*);

    // Shadow copy of the lighting registers, updated on the same edge as the block's.
    logic [1:0]  sh_count = '0;
    logic [47:0] sh_kd = '0;
    logic [23:0] sh_int [2] = '{default: '0};
    logic [47:0] sh_dir [2] = '{default: '0};

    logic [IN_W-1:0]  polygons [$];
    logic [OUT_W-1:0] shaded_colours [$];
    logic in_took = 1'b0;
    logic idle_on = 1'b0;
    logic want_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   mismatches = 0;
    int   cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Lambert term per channel: base plus intensity * kd * (L . n_unit), floored and clamped.
    function automatic logic [OUT_W-1:0] shade(logic [IN_W-1:0] d);
        longint n [3];
        longint unsigned mag [3];
        bit neg [3];
        longint acc [3];
        longint unsigned maxm, q2, x, root, bitv, dm, qm;
        longint dd, dotv, ival, kd;
        int lights;
        logic [OUT_W-1:0] res;
        maxm = 0;
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = longint'(d[3*NB+8*c +: 8]) <<< 29;
            n[c] = $signed(d[NB*c +: NB]);
            neg[c] = n[c] < 0;
            mag[c] = neg[c] ? -n[c] : n[c];
            if (mag[c] > maxm)
                maxm = mag[c];
        end
        lights = (sh_count > 2) ? 2 : int'(sh_count);
        if (maxm != 0 && lights != 0)
        begin
            // bring the largest magnitude into [2^14, 2^15), truncating on the way down
            while (maxm >= 64'd32768)
            begin
                maxm = maxm >> 1;
                for (int c = 0; c < 3; c++)
                    mag[c] = mag[c] >> 1;
            end
            while (maxm < 64'd16384)
            begin
                maxm = maxm << 1;
                for (int c = 0; c < 3; c++)
                    mag[c] = mag[c] << 1;
            end
            q2 = 0;
            for (int c = 0; c < 3; c++)
            begin
                n[c] = neg[c] ? -longint'(mag[c]) : longint'(mag[c]);
                q2 += mag[c] * mag[c];
            end
            // integer square root of the squared length in Q.28
            x = q2 << 28;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= root + bitv)
                begin
                    x = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            for (int l = 0; l < lights; l++)
            begin
                dd = 0;
                for (int k = 0; k < 3; k++)
                    dd += longint'($signed(sh_dir[l][16*k +: 16])) * n[k];
                dm = (dd < 0) ? -dd : dd;
                qm = (dm << 14) / root;
                dotv = (dd < 0) ? -longint'(qm) : longint'(qm);
                for (int c = 0; c < 3; c++)
                begin
                    ival = longint'(sh_int[l][8*c +: 8]);
                    kd = longint'(sh_kd[16*c +: 16]);
                    acc[c] += ival * kd * dotv;
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            if (acc[c] < 0)
                res[8*c +: 8] = '0;
            else if ((acc[c] >>> 29) > 255)
                res[8*c +: 8] = CH_MAX;
            else
                res[8*c +: 8] = acc[c][36:29];
        end
        return res;
    endfunction

    function automatic logic [NB-1:0] rand_component();
        logic [NB-1:0] v;
        v = NB'($urandom);
        // spread the magnitudes so every scaling direction gets exercised
        return $signed(v) >>> $urandom_range(NB-1);
    endfunction

    function automatic logic [IN_W-1:0] polygon(logic [NB-1:0] nx, logic [NB-1:0] ny,
                                               logic [NB-1:0] nz, logic [23:0] rgb);
        return {rgb, nz, ny, nx};
    endfunction

    // Sender: present a new beat once the previous one has gone, idling now and then.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_took))
        begin
            if (polygons.size() > 0 && !(idle_on && $urandom_range(99) < 11))
            begin
                s_axis_tdata  <= polygons.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the pipeline up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (want_hold && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt <= 400;
                hold_done <= 1'b1;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99) < 11);
        end
    end

    // Input side: predict each accepted polygon; track register writes.
    always @(posedge clk)
    begin
        in_took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            shaded_colours.push_back(shade(s_axis_tdata));
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_LIGHT_COUNT:    sh_count  <= cfg_wdata[1:0];
                REG_DIFFUSE_COEFFS: sh_kd     <= cfg_wdata;
                REG_L0_INTENSITY:   sh_int[0] <= cfg_wdata[23:0];
                REG_L0_DIRECTION:   sh_dir[0] <= cfg_wdata;
                REG_L1_INTENSITY:   sh_int[1] <= cfg_wdata[23:0];
                REG_L1_DIRECTION:   sh_dir[1] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Output side: compare each beat against the oldest prediction, channel by channel.
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (shaded_colours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %h", m_axis_tdata);
            end
            else
            begin
                want = shaded_colours.pop_front();
                for (int c = 0; c < 3; c++)
                begin
                    if (want[8*c +: 8] !== m_axis_tdata[8*c +: 8])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("channel %0d: expected %0d got %0d", c,
                                     want[8*c +: 8], m_axis_tdata[8*c +: 8]);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic light_setup(logic [1:0] cnt, logic [47:0] kd, logic [23:0] i0,
                               logic [47:0] d0, logic [23:0] i1, logic [47:0] d1);
        put_reg(REG_LIGHT_COUNT, CFG_W'(cnt));
        put_reg(REG_DIFFUSE_COEFFS, kd);
        put_reg(REG_L0_INTENSITY, CFG_W'(i0));
        put_reg(REG_L0_DIRECTION, d0);
        put_reg(REG_L1_INTENSITY, CFG_W'(i1));
        put_reg(REG_L1_DIRECTION, d1);
    endtask

    // Wait until every queued polygon has gone in and every colour has come back.
    task automatic drain();
        while (polygons.size() > 0 || s_axis_tvalid || shaded_colours.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_polygons(int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(19) == 0)
                polygons.push_back(polygon('0, '0, '0, 24'($urandom)));
            else
                polygons.push_back(polygon(rand_component(), rand_component(),
                                           rand_component(), 24'($urandom)));
        end
    endtask

    initial
    begin
        logic [NB-1:0] pmax, pmin;
        pmax = {1'b0, {(NB-1){1'b1}}};
        pmin = {1'b1, {(NB-1){1'b0}}};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: two strong lights along +z and -x, full coefficients.
        light_setup(2'd2, 48'h8000_8000_8000, 24'hFF_FF_FF, {16'h4000, 16'h0, 16'h0},
                    24'h80_40_20, {16'h0, 16'h0, 16'hC000});
        polygons.push_back(polygon('0, '0, '0, 24'h12_34_56));
        polygons.push_back(polygon('0, '0, 24'd1, 24'h00_00_00));
        polygons.push_back(polygon('0, '0, -24'sd1, 24'hFF_FF_FF));
        polygons.push_back(polygon('0, '0, pmax, 24'h80_80_80));
        polygons.push_back(polygon('0, '0, pmin, 24'h80_80_80));
        polygons.push_back(polygon(pmin, pmin, pmin, 24'h00_00_00));
        polygons.push_back(polygon(pmax, pmax, pmax, 24'hFF_FF_FF));
        polygons.push_back(polygon(pmin, pmax, '0, 24'h01_7F_FE));
        polygons.push_back(polygon(24'd1, '0, '0, 24'h00_00_00));
        polygons.push_back(polygon(-24'sd1, '0, '0, 24'h00_00_00));
        polygons.push_back(polygon(24'd16384, '0, 24'd16384, 24'hFF_00_FF));
        polygons.push_back(polygon(24'd32767, 24'd32768, '0, 24'h55_AA_55));
        polygons.push_back(polygon(24'd3, 24'd4, 24'd5, 24'hAA_55_AA));
        polygons.push_back(polygon('0, '0, 24'd7, 24'hFE_FE_FE));
        drain();

        // No lights: colour passes straight through.
        light_setup(2'd0, 48'hFFFF_FFFF_FFFF, 24'hFF_FF_FF, 48'hFFFF_FFFF_FFFF,
                    24'hFF_FF_FF, 48'hFFFF_FFFF_FFFF);
        polygons.push_back(polygon(pmax, pmin, 24'd5, 24'h10_20_30));
        polygons.push_back(polygon('0, '0, '0, 24'hFF_00_FF));
        idle_on = 1'b1;
        random_polygons(150);
        drain();

        // Count above the limit saturates; extreme register contents.
        light_setup(2'd3, 48'hFFFF_FFFF_FFFF, 24'hFF_FF_FF, {16'h7FFF, 16'h8000, 16'h7FFF},
                    24'hFF_FF_FF, {16'h8000, 16'h7FFF, 16'h8000});
        random_polygons(200);
        drain();

        // One light only, long stretch with no idling.
        idle_on = 1'b0;
        light_setup(2'd1, 48'({$urandom, $urandom}), 24'($urandom),
                    48'({$urandom, $urandom}), 24'($urandom), 48'({$urandom, $urandom}));
        random_polygons(200);
        drain();

        // Receiver holds off while the sender keeps offering beats.
        idle_on = 1'b1;
        want_hold = 1'b1;
        light_setup(2'd2, 48'h0000_0000_0000, '0, '0, '0, '0);
        random_polygons(200);
        drain();

        // Random lighting setups.
        for (int p = 0; p < 4; p++)
        begin
            light_setup(2'($urandom_range(3)), 48'({$urandom, $urandom}), 24'($urandom),
                        48'({$urandom, $urandom}), 24'($urandom),
                        48'({$urandom, $urandom}));
            random_polygons(200);
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
src/fsh_pkg.sv
src/fsh_sqrt.sv
src/fsh_div.sv
src/flat_directional_shading.sv
tb/sv/tb_top.sv
